// ===== rtl/tickless_timer_reload_macros.svh =====
// ----------------------------------------------------------------------------
// tickless_timer_reload_macros
// Assertion macros used by the timer sequencer (tt_ctrl).
// ----------------------------------------------------------------------------
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef TICKLESS_TIMER_RELOAD_MACROS_SVH
`define TICKLESS_TIMER_RELOAD_MACROS_SVH

// Same-cycle implication.
`define TT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg
// Shared types and constants of the tickless timer with autoreload.
// ----------------------------------------------------------------------------
package tt_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam logic [15:0] CPT_RESET = 16'd32;
  localparam logic signed [16:0] TICKS_FOREVER = -17'sd1;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_TIMEOUT = 2'd1,
    FUNC_ELAPSED = 2'd2,
    FUNC_SERVICE = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV_MAX,
    S_WAIT_MAX,
    S_DIV_OP,
    S_WAIT_OP,
    S_MUL_NEXT,
    S_MUL_MAX,
    S_CLAMP,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_MAX,
    DIV_COUNT,
    DIV_ELAPSED,
    DIV_ANNOUNCE
  } div_sel_t;

  typedef enum logic {
    MUL_NEXT,
    MUL_MAX
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_max;
    logic     cap_t;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     clamp;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  div_busy;
    logic  div_done;
    logic  out_free;
  } status_t;

endpackage

// ===== rtl/tt_if.sv =====
// ----------------------------------------------------------------------------
// tt_if
// Valid/ready channels for timer requests and timer results.
// ----------------------------------------------------------------------------
interface tt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [16:0] ticks;
  logic               idle;

  modport source (output valid, func, ticks, idle, input ready);
  modport sink   (input valid, func, ticks, idle, output ready);
endinterface

interface tt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ticks;
  logic [15:0] announce_ticks;
  logic        announce_valid;
  logic        reload_written;
  logic [15:0] reload_value;

  modport source (output valid, elapsed_ticks, announce_ticks, announce_valid,
                  reload_written, reload_value, input ready);
  modport sink   (input valid, elapsed_ticks, announce_ticks, announce_valid,
                  reload_written, reload_value, output ready);
endinterface

// ===== rtl/tt_div.sv =====
// ----------------------------------------------------------------------------
// tt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tt_div #(
  parameter int DW = 17,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      rem_sh;
  logic [VW:0]      diff;

  assign rem_sh = {rem, quo[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        // The top bit of diff is the borrow: set when the divisor did not fit.
        if (!diff[VW]) begin
          rem <= diff[VW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[VW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/tt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tt_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
`include "tickless_timer_reload_macros.svh"

module tt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tt_pkg::status_t  status,
  output tt_pkg::cmd_t     cmd
);

  tt_pkg::state_t state;
  tt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = tt_pkg::DIV_MAX;
    cmd.mul_sel   = tt_pkg::MUL_NEXT;
    req_ready     = 1'b0;
    case (state)
      tt_pkg::S_IDLE: begin
        // No item is taken while reset is held.
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = tt_pkg::S_DISPATCH;
        end
      end
      tt_pkg::S_DISPATCH: begin
        case (status.func)
          tt_pkg::FUNC_TICK:    state_next = tt_pkg::S_FINISH;
          tt_pkg::FUNC_TIMEOUT: state_next = tt_pkg::S_DIV_MAX;
          default:              state_next = tt_pkg::S_DIV_OP;
        endcase
      end
      tt_pkg::S_DIV_MAX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tt_pkg::DIV_MAX;
        state_next    = tt_pkg::S_WAIT_MAX;
      end
      tt_pkg::S_WAIT_MAX: begin
        if (status.div_done) begin
          cmd.cap_max = 1'b1;
          state_next  = tt_pkg::S_DIV_OP;
        end
      end
      tt_pkg::S_DIV_OP: begin
        cmd.div_start = 1'b1;
        case (status.func)
          tt_pkg::FUNC_TIMEOUT: begin
            cmd.div_sel = tt_pkg::DIV_COUNT;
            cmd.cap_t   = 1'b1;
          end
          tt_pkg::FUNC_ELAPSED: cmd.div_sel = tt_pkg::DIV_ELAPSED;
          default:              cmd.div_sel = tt_pkg::DIV_ANNOUNCE;
        endcase
        state_next = tt_pkg::S_WAIT_OP;
      end
      tt_pkg::S_WAIT_OP: begin
        if (status.div_done) begin
          if (status.func == tt_pkg::FUNC_TIMEOUT) begin
            state_next = tt_pkg::S_MUL_NEXT;
          end else begin
            state_next = tt_pkg::S_FINISH;
          end
        end
      end
      tt_pkg::S_MUL_NEXT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tt_pkg::MUL_NEXT;
        state_next  = tt_pkg::S_MUL_MAX;
      end
      tt_pkg::S_MUL_MAX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tt_pkg::MUL_MAX;
        state_next  = tt_pkg::S_CLAMP;
      end
      tt_pkg::S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = tt_pkg::S_FINISH;
      end
      tt_pkg::S_FINISH: begin
        // Hold the finished item until the result register can take it.
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = tt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tt_pkg::S_IDLE;
      end
    endcase
  end

  `TT_ASSERT_IMPL(a_commit_free, cmd.commit, status.out_free, "commit with result slot full")
  `TT_ASSERT_IMPL(a_start_idle, cmd.div_start, !status.div_busy, "divider restarted while busy")
  `TT_ASSERT_NEXT(a_done_seen, status.div_done && (state == tt_pkg::S_WAIT_OP),
                  state != tt_pkg::S_WAIT_OP, "division result missed")
  `TT_ASSERT_NEXT(a_commit_idle, cmd.commit, req_ready, "not ready after finishing an item")

endmodule

// ===== rtl/tt_dp.sv =====
// ----------------------------------------------------------------------------
// tt_dp
// Timer state, configuration register, divider, multiplier and result register.
// ----------------------------------------------------------------------------
module tt_dp #(
  parameter int COUNT_WIDTH = tt_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic [1:0]         req_func,
  input  logic signed [16:0] req_ticks,
  input  logic               req_idle,
  input  logic               rsp_ready,
  input  tt_pkg::cmd_t       cmd,
  output tt_pkg::status_t    status,
  output logic               rsp_valid,
  output logic [15:0]        rsp_elapsed_ticks,
  output logic [15:0]        rsp_announce_ticks,
  output logic               rsp_announce_valid,
  output logic               rsp_reload_written,
  output logic [15:0]        rsp_reload_value
);

  localparam int DW = COUNT_WIDTH + 1;   // dividend width
  localparam int MW = COUNT_WIDTH + 2;   // multiplier operand width
  localparam int W  = COUNT_WIDTH + 19;  // signed working width

  // Timer state.
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] reload;
  logic                   pending;
  logic                   running;
  logic [15:0]            cpt_cfg;

  // Latched request.
  tt_pkg::func_t      func_r;
  logic signed [16:0] ticks_r;
  logic               idle_r;
  logic [15:0]        c_r;

  // Working registers for the timeout calculation.
  logic signed [W-1:0] mt_r;
  logic signed [W-1:0] t_r;
  logic signed [W-1:0] prod_r;
  logic signed [W-1:0] mc_r;
  logic signed [W-1:0] nm1_r;

  logic [DW-1:0] div_dividend;
  logic [DW-1:0] quo;
  logic          div_busy;
  logic          div_done;

  tt_div #(.DW(DW), .VW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (c_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    case (cmd.div_sel)
      tt_pkg::DIV_MAX:     div_dividend = {1'b0, {COUNT_WIDTH{1'b1}}};
      tt_pkg::DIV_COUNT:   div_dividend = {1'b0, count};
      tt_pkg::DIV_ELAPSED: div_dividend = {1'b0, count} +
                                          (pending ? ({1'b0, reload} + DW'(1)) : '0);
      default:             div_dividend = {1'b0, reload} + DW'(1);
    endcase
  end

  // Largest tick count and clamped tick request.
  logic signed [W-1:0] mt_new;
  logic signed [W-1:0] tk_w;
  logic signed [W-1:0] t0;
  logic signed [W-1:0] t1;
  logic signed [W-1:0] t_new;

  assign mt_new = $signed(W'(quo)) - 1;
  assign tk_w   = $signed({{(W-17){ticks_r[16]}}, ticks_r});
  assign t0     = (ticks_r == tt_pkg::TICKS_FOREVER) ? mt_r : tk_w;
  assign t1     = t0 - 1;
  assign t_new  = (t1 <= 1) ? W'(1) : ((t1 > mt_r) ? mt_r : t1);

  // Shared multiplier against the tick length.
  logic signed [W-1:0] sum_next;
  logic [MW-1:0]       mul_a;
  logic [MW+15:0]      prod;

  assign sum_next = $signed(W'(quo)) + 1 + t_r;
  assign mul_a    = (cmd.mul_sel == tt_pkg::MUL_NEXT) ? sum_next[MW-1:0] : mt_r[MW-1:0];
  assign prod     = mul_a * c_r;

  // Bound the new reload between the guard point and the maximum cycle count.
  logic signed [W-1:0] lp1;
  logic signed [W-1:0] nx;

  assign lp1 = $signed(W'(count)) + 1;
  assign nx  = (prod_r > mc_r) ? mc_r : ((prod_r < lp1) ? lp1 : prod_r);

  // State update and result on commit.
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] reload_next;
  logic                   pending_next;
  logic                   running_next;
  logic [15:0]            elapsed_next;
  logic [15:0]            announce_next;
  logic                   valid_next;
  logic                   written_next;
  logic                   stop;
  logic                   wr;
  logic [DW+15:0]         quo_ext;
  logic [COUNT_WIDTH+15:0] reload_ext;

  assign quo_ext    = {16'b0, quo};
  assign reload_ext = {16'b0, reload_next};
  assign stop       = idle_r && (ticks_r == tt_pkg::TICKS_FOREVER);
  assign wr         = !stop && !pending && (count != reload) && (nm1_r > 0) &&
                      (nm1_r != $signed(W'(reload)));

  always_comb begin
    count_next    = count;
    reload_next   = reload;
    pending_next  = pending;
    running_next  = running;
    elapsed_next  = '0;
    announce_next = '0;
    valid_next    = 1'b0;
    written_next  = 1'b0;
    case (func_r)
      tt_pkg::FUNC_TICK: begin
        if (running) begin
          if (count == reload) begin
            count_next   = '0;
            pending_next = 1'b1;
          end else begin
            count_next = count + COUNT_WIDTH'(1);
          end
        end
      end
      tt_pkg::FUNC_TIMEOUT: begin
        running_next = !stop;
        if (wr) begin
          reload_next  = nm1_r[COUNT_WIDTH-1:0];
          written_next = 1'b1;
        end
      end
      tt_pkg::FUNC_ELAPSED: begin
        elapsed_next = quo_ext[15:0];
      end
      tt_pkg::FUNC_SERVICE: begin
        if (pending) begin
          pending_next  = 1'b0;
          announce_next = quo_ext[15:0];
          valid_next    = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      reload    <= '1;
      pending   <= 1'b0;
      running   <= 1'b1;
      cpt_cfg   <= tt_pkg::CPT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cpt_cfg <= cfg_wdata;
      end
      if (cmd.load) begin
        func_r  <= tt_pkg::func_t'(req_func);
        ticks_r <= req_ticks;
        idle_r  <= req_idle;
        // A tick length of zero counts as one.
        c_r     <= (cpt_cfg == 16'd0) ? 16'd1 : cpt_cfg;
      end
      if (cmd.cap_max) begin
        mt_r <= mt_new;
      end
      if (cmd.cap_t) begin
        t_r <= t_new;
      end
      if (cmd.mul_en) begin
        if (cmd.mul_sel == tt_pkg::MUL_NEXT) begin
          prod_r <= $signed(W'(prod));
        end else begin
          mc_r <= (mt_r < 0) ? '0 : $signed(W'(prod));
        end
      end
      if (cmd.clamp) begin
        nm1_r <= nx - 1;
      end
      if (cmd.commit) begin
        count              <= count_next;
        reload             <= reload_next;
        pending            <= pending_next;
        running            <= running_next;
        rsp_valid          <= 1'b1;
        rsp_elapsed_ticks  <= elapsed_next;
        rsp_announce_ticks <= announce_next;
        rsp_announce_valid <= valid_next;
        rsp_reload_written <= written_next;
        rsp_reload_value   <= reload_ext[15:0];
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status.func     = func_r;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/tickless_timer_reload.sv =====
// A clock tick runs no division; an elapsed query or service runs one division; a
// timeout runs two divisions and two multiplications. The serial divider yields
// one quotient bit per cycle. Only one item is in work at a time; the result
// register lets the next item start while a result waits.
// Synchronous reset clears the counter, sets the reload to all ones and the tick length to 32.
// ----------------------------------------------------------------------------
// tickless_timer_reload
// Tickless kernel timer: autoreload counter with timeout, elapsed and service.
// ----------------------------------------------------------------------------
module tickless_timer_reload #(
  parameter int COUNT_WIDTH = tt_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  tt_req_if.sink      req,
  tt_rsp_if.source    rsp
);

  tt_pkg::cmd_t    cmd;
  tt_pkg::status_t status;

  tt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tt_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .req_func           (req.func),
    .req_ticks          (req.ticks),
    .req_idle           (req.idle),
    .rsp_ready          (rsp.ready),
    .cmd                (cmd),
    .status             (status),
    .rsp_valid          (rsp.valid),
    .rsp_elapsed_ticks  (rsp.elapsed_ticks),
    .rsp_announce_ticks (rsp.announce_ticks),
    .rsp_announce_valid (rsp.announce_valid),
    .rsp_reload_written (rsp.reload_written),
    .rsp_reload_value   (rsp.reload_value)
  );

endmodule
